// ===== hdl/v4n_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package v4n_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COMP_W     = 32;
    localparam int PROD_W     = 2 * COMP_W;
    // Four full products summed exactly, plus room for sign.
    localparam int SUM_W      = PROD_W + 2;
    localparam int SQ_N_W     = PROD_W + 1;
    localparam int SQ_WK_W    = PROD_W + 2;
    localparam int ROOT_W     = COMP_W + 1;
    localparam int SQ_STAGES  = ROOT_W;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int DIV_STAGES = QUO_W;
    localparam int DVD_W      = COMP_W + FRAC_BITS;
    localparam int CMP_W      = ROOT_W + FRAC_BITS;
    localparam int SIDE_LEN   = SQ_STAGES + DIV_STAGES;

    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_DOT  = 3'd3;
    localparam logic [2:0] MODE_LEN  = 3'd4;
    localparam logic [2:0] MODE_NORM = 3'd5;
    localparam logic [2:0] MODE_NEG  = 3'd6;

    localparam logic signed [COMP_W-1:0] MAX_VAL = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic signed [COMP_W-1:0] MIN_VAL = {1'b1, {(COMP_W-1){1'b0}}};

    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct packed {
        comp_t val;
        logic  ovf;
    } sat_t;

    typedef struct packed {
        logic [2:0]                   mode;
        logic [3:0][COMP_W-1:0]       vec;
        comp_t                        dot;
        logic                         ovf;
        logic [3:0][COMP_W-1:0]       mag;
        logic [3:0]                   neg;
    } side_t;

    function automatic sat_t sat_comp(input logic signed [SUM_W-1:0] v);
        sat_t s;
        if (v > SUM_W'(MAX_VAL)) begin
            s.val = MAX_VAL;
            s.ovf = 1'b1;
        end else if (v < SUM_W'(MIN_VAL)) begin
            s.val = MIN_VAL;
            s.ovf = 1'b1;
        end else begin
            s.val = v[COMP_W-1:0];
            s.ovf = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/v4n_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module v4n_sqrt (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [v4n_pkg::SQ_N_W-1:0]   n,
    output logic      [v4n_pkg::ROOT_W-1:0]   root
);

    localparam int WK = v4n_pkg::SQ_WK_W;
    localparam int NS = v4n_pkg::SQ_STAGES;

    logic [WK-1:0] x_reg   [NS];
    logic [WK-1:0] res_reg [NS];

    // One result bit per stage, most significant first.
    for (genvar s = 0; s < NS; s++) begin : g_st
        localparam logic [WK-1:0] BIT = WK'(1) << (2 * (NS - 1 - s));
        logic [WK-1:0] xi, ri, t, x_next, res_next;

        if (s == 0) begin : g_first
            assign xi = WK'(n);
            assign ri = '0;
        end else begin : g_rest
            assign xi = x_reg[s-1];
            assign ri = res_reg[s-1];
        end

        always_comb begin
            t = ri + BIT;
            if (xi >= t) begin
                x_next   = xi - t;
                res_next = (ri >> 1) + BIT;
            end else begin
                x_next   = xi;
                res_next = ri >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[s]   <= x_next;
                res_reg[s] <= res_next;
            end
        end
    end

    assign root = res_reg[NS-1][v4n_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/v4n_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module v4n_div (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [v4n_pkg::COMP_W-1:0]   mag,
    input  wire logic [v4n_pkg::ROOT_W-1:0]   divisor,
    output logic      [v4n_pkg::QUO_W-1:0]    quo,
    output logic      [v4n_pkg::ROOT_W-1:0]   divisor_out
);

    localparam int NS = v4n_pkg::DIV_STAGES;
    localparam int FB = v4n_pkg::FRAC_BITS;
    localparam int DW = v4n_pkg::DVD_W;
    localparam int CW = v4n_pkg::CMP_W;
    localparam int QW = v4n_pkg::QUO_W;
    localparam int LW = v4n_pkg::ROOT_W;

    logic [DW-1:0] rem_reg [NS];
    logic [QW-1:0] q_reg   [NS];
    logic [LW-1:0] d_reg   [NS];

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < NS; k++) begin : g_st
        localparam int SH = NS - 1 - k;
        logic [DW-1:0] ri, rem_next;
        logic [QW-1:0] qi, q_next;
        logic [LW-1:0] di;
        logic [CW-1:0] dsh;

        if (k == 0) begin : g_first
            assign ri = {mag, {FB{1'b0}}};
            assign qi = '0;
            assign di = divisor;
        end else begin : g_rest
            assign ri = rem_reg[k-1];
            assign qi = q_reg[k-1];
            assign di = d_reg[k-1];
        end

        always_comb begin
            dsh = CW'(di) << SH;
            if (CW'(ri) >= dsh) begin
                rem_next = DW'(CW'(ri) - dsh);
                q_next   = qi | (QW'(1) << SH);
            end else begin
                rem_next = ri;
                q_next   = qi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
                d_reg[k]   <= di;
            end
        end
    end

    assign quo         = q_reg[NS-1];
    assign divisor_out = d_reg[NS-1];

endmodule

`default_nettype wire

// ===== hdl/vec4_alu_normalize.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four-component signed Q16.16 vector unit: add, subtract, multiply, negate,
// dot product, length and normalize. One word enters per cycle while the
// pipeline is not stalled; the depth is set by the 33-stage square root
// (one root bit per stage) followed by the 17-stage dividers (one quotient bit
// per stage) that normalize needs, and every mode runs the full depth so that
// results leave in order. The whole pipeline advances only when the output
// register is empty or being taken, so a stall holds every word in place.
// Saturated results raise overflow; a zero vector normalizes to zero.
module vec4_alu_normalize (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_mode,
    input  wire logic signed [31:0] s_a_x,
    input  wire logic signed [31:0] s_a_y,
    input  wire logic signed [31:0] s_a_z,
    input  wire logic signed [31:0] s_a_w,
    input  wire logic signed [31:0] s_b_x,
    input  wire logic signed [31:0] s_b_y,
    input  wire logic signed [31:0] s_b_z,
    input  wire logic signed [31:0] s_b_w,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [31:0] m_r_x,
    output logic signed [31:0] m_r_y,
    output logic signed [31:0] m_r_z,
    output logic signed [31:0] m_r_w,
    output logic signed [31:0] m_scalar,
    output logic             m_overflow
);

    localparam int SW = v4n_pkg::SUM_W;
    localparam int FB = v4n_pkg::FRAC_BITS;
    localparam int NL = v4n_pkg::SIDE_LEN;
    localparam int PW = v4n_pkg::PROD_W;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Stage 1: input capture.
    logic                 v1_reg;
    logic [2:0]           mode1_reg;
    v4n_pkg::comp_t       a1_reg [4];
    v4n_pkg::comp_t       b1_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= s_mode;
            a1_reg[0] <= s_a_x;
            a1_reg[1] <= s_a_y;
            a1_reg[2] <= s_a_z;
            a1_reg[3] <= s_a_w;
            b1_reg[0] <= s_b_x;
            b1_reg[1] <= s_b_y;
            b1_reg[2] <= s_b_z;
            b1_reg[3] <= s_b_w;
        end
    end

    // Stage 2: products and the simple component-wise operations.
    logic                        v2_reg;
    logic [2:0]                  mode2_reg;
    logic signed [v4n_pkg::PROD_W-1:0] prod2_reg [4];
    logic signed [v4n_pkg::PROD_W-1:0] prod2_next [4];
    v4n_pkg::comp_t              vec2_reg [4];
    v4n_pkg::comp_t              vec2_next [4];
    logic [3:0]                  ovf2_reg, ovf2_next;
    logic [3:0][31:0]            mag2_reg, mag2_next;
    logic [3:0]                  neg2_reg, neg2_next;

    always_comb begin
        logic signed [SW-1:0] ea, eb, r;
        v4n_pkg::sat_t        s;
        v4n_pkg::comp_t       mb;
        for (int i = 0; i < 4; i++) begin
            ea = SW'(a1_reg[i]);
            eb = SW'(b1_reg[i]);
            unique case (mode1_reg)
                v4n_pkg::MODE_ADD: r = ea + eb;
                v4n_pkg::MODE_SUB: r = ea - eb;
                v4n_pkg::MODE_NEG: r = -ea;
                default:           r = '0;
            endcase
            s = v4n_pkg::sat_comp(r);
            vec2_next[i] = s.val;
            ovf2_next[i] = s.ovf;
            // Length and normalize square the first vector.
            mb = (mode1_reg == v4n_pkg::MODE_LEN || mode1_reg == v4n_pkg::MODE_NORM)
                 ? a1_reg[i] : b1_reg[i];
            prod2_next[i] = PW'(a1_reg[i]) * PW'(mb);
            neg2_next[i]  = a1_reg[i][31];
            mag2_next[i]  = a1_reg[i][31] ? 32'(32'd0 - a1_reg[i]) : a1_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode2_reg <= mode1_reg;
            prod2_reg <= prod2_next;
            vec2_reg  <= vec2_next;
            ovf2_reg  <= ovf2_next;
            mag2_reg  <= mag2_next;
            neg2_reg  <= neg2_next;
        end
    end

    // Stage 3: exact sum of products and the truncated multiply results.
    logic                 v3_reg;
    logic [2:0]           mode3_reg;
    logic signed [SW-1:0] sum3_reg, sum3_next;
    logic [3:0][31:0]     vec3_reg, vec3_next;
    logic                 ovf3_reg, ovf3_next;
    logic [3:0][31:0]     mag3_reg;
    logic [3:0]           neg3_reg;

    always_comb begin
        v4n_pkg::sat_t s;
        logic [3:0]    ov;
        sum3_next = SW'(prod2_reg[0]) + SW'(prod2_reg[1])
                  + SW'(prod2_reg[2]) + SW'(prod2_reg[3]);
        for (int i = 0; i < 4; i++) begin
            s = v4n_pkg::sat_comp(SW'(prod2_reg[i] >>> FB));
            if (mode2_reg == v4n_pkg::MODE_MUL) begin
                vec3_next[i] = s.val;
                ov[i]        = s.ovf;
            end else begin
                vec3_next[i] = vec2_reg[i];
                ov[i]        = ovf2_reg[i];
            end
        end
        ovf3_next = |ov;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode3_reg <= mode2_reg;
            sum3_reg  <= sum3_next;
            vec3_reg  <= vec3_next;
            ovf3_reg  <= ovf3_next;
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
        end
    end

    // Side line that carries each word alongside the root and the dividers.
    v4n_pkg::side_t side_in;
    v4n_pkg::side_t side_reg [NL];
    logic [NL-1:0]  vld_reg;

    always_comb begin
        v4n_pkg::sat_t d;
        d = v4n_pkg::sat_comp(sum3_reg >>> FB);
        side_in.mode = mode3_reg;
        side_in.vec  = vec3_reg;
        side_in.mag  = mag3_reg;
        side_in.neg  = neg3_reg;
        if (mode3_reg == v4n_pkg::MODE_DOT) begin
            side_in.dot = d.val;
            side_in.ovf = d.ovf;
        end else begin
            side_in.dot = '0;
            side_in.ovf = ovf3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NL-2:0], v3_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int j = 1; j < NL; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    logic [v4n_pkg::ROOT_W-1:0] root;

    v4n_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .n    (sum3_reg[v4n_pkg::SQ_N_W-1:0]),
        .root (root)
    );

    logic [v4n_pkg::QUO_W-1:0]  quo  [4];
    logic [v4n_pkg::ROOT_W-1:0] dlen [4];

    for (genvar i = 0; i < 4; i++) begin : g_div
        v4n_div u_div (
            .aclk        (aclk),
            .en          (en),
            .mag         (side_reg[v4n_pkg::SQ_STAGES-1].mag[i]),
            .divisor     (root),
            .quo         (quo[i]),
            .divisor_out (dlen[i])
        );
    end

    // Output register.
    v4n_pkg::side_t   tail;
    logic [3:0][31:0] r_next;
    logic [31:0]      scalar_next;
    logic             ovf_next;

    assign tail = side_reg[NL-1];

    always_comb begin
        r_next      = '0;
        scalar_next = '0;
        ovf_next    = 1'b0;
        unique case (tail.mode)
            v4n_pkg::MODE_ADD, v4n_pkg::MODE_SUB,
            v4n_pkg::MODE_MUL, v4n_pkg::MODE_NEG: begin
                r_next   = tail.vec;
                ovf_next = tail.ovf;
            end
            v4n_pkg::MODE_DOT: begin
                scalar_next = tail.dot;
                ovf_next    = tail.ovf;
            end
            v4n_pkg::MODE_LEN: begin
                if (dlen[0][32] || dlen[0][31]) begin
                    scalar_next = v4n_pkg::MAX_VAL;
                    ovf_next    = 1'b1;
                end else begin
                    scalar_next = dlen[0][31:0];
                end
            end
            v4n_pkg::MODE_NORM: begin
                if (dlen[0] != '0) begin
                    for (int i = 0; i < 4; i++) begin
                        r_next[i] = tail.neg[i] ? 32'(32'd0 - 32'(quo[i]))
                                                : 32'(quo[i]);
                    end
                end
            end
            default: begin
                r_next = '0;
            end
        endcase
    end

    logic m_valid_reg;
    logic [3:0][31:0] m_r_reg;
    logic [31:0] m_scalar_reg;
    logic m_overflow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[NL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_r_reg        <= r_next;
            m_scalar_reg   <= scalar_next;
            m_overflow_reg <= ovf_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_r_x      = m_r_reg[0];
    assign m_r_y      = m_r_reg[1];
    assign m_r_z      = m_r_reg[2];
    assign m_r_w      = m_r_reg[3];
    assign m_scalar   = m_scalar_reg;
    assign m_overflow = m_overflow_reg;

endmodule

`default_nettype wire

// ===== hdl/v4n_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module v4n_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_r_x,
    input wire logic [31:0] m_r_y,
    input wire logic [31:0] m_r_z,
    input wire logic [31:0] m_r_w,
    input wire logic [31:0] m_scalar,
    input wire logic        m_overflow
);

    // An empty output register never holds back the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word shown right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_r_x) && $stable(m_scalar)
                                && $stable(m_overflow))
        else $error("stalled result word changed");

    // A saturated word always carries a value at one of the rails.
    a_ovf_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |->
            m_r_x == 32'h7fffffff || m_r_x == 32'h80000000 ||
            m_r_y == 32'h7fffffff || m_r_y == 32'h80000000 ||
            m_r_z == 32'h7fffffff || m_r_z == 32'h80000000 ||
            m_r_w == 32'h7fffffff || m_r_w == 32'h80000000 ||
            m_scalar == 32'h7fffffff || m_scalar == 32'h80000000)
        else $error("overflow without a saturated value");

endmodule

bind vec4_alu_normalize v4n_checker u_v4n_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_r_x      (m_r_x),
    .m_r_y      (m_r_y),
    .m_r_z      (m_r_z),
    .m_r_w      (m_r_w),
    .m_scalar   (m_scalar),
    .m_overflow (m_overflow)
);

`default_nettype wire
